@@ hdl/itoa_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// itoa_pkg: shared types and constants of the integer-to-ASCII formatter
// Item structs, mode codes, sequencer states and character constants.
// ----------------------------------------------------------------------------
package itoa_pkg;

  localparam int unsigned MODE_W  = 3;
  localparam int unsigned VALUE_W = 64;
  localparam int unsigned WIDTH_W = 6;
  localparam int unsigned CHAR_W  = 8;

  // conversion codes; unused codes format as unsigned decimal
  localparam logic [MODE_W-1:0] MODE_SDEC = 3'd0;
  localparam logic [MODE_W-1:0] MODE_UDEC = 3'd1;
  localparam logic [MODE_W-1:0] MODE_HEXL = 3'd2;
  localparam logic [MODE_W-1:0] MODE_HEXU = 3'd3;
  localparam logic [MODE_W-1:0] MODE_PTR  = 3'd4;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_X     = 8'h78;

  localparam logic [WIDTH_W-1:0] PTR_DEF_WIDTH = 6'd8;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [VALUE_W-1:0] value;
    logic [WIDTH_W-1:0] field_width;
    logic               zero_fill;
    logic               force_plus;
    logic               space_sign;
    logic               alt_form;
    logic               has_precision;
    logic [WIDTH_W-1:0] precision;
  } in_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] out_char;
    logic              last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SCAN,
    ST_PREFIX,
    ST_PAD,
    ST_DIGIT
  } state_e;

  // one digit (0..15) to its ASCII character
  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] nib,
                                                  input logic upper);
    logic [CHAR_W-1:0] c;
    if (nib < 4'd10) begin
      c = CH_ZERO + {4'd0, nib};
    end else if (upper) begin
      c = 8'h41 + {4'd0, nib - 4'd10};
    end else begin
      c = 8'h61 + {4'd0, nib - 4'd10};
    end
    return c;
  endfunction

endpackage
`default_nettype wire

@@ hdl/integer_to_ascii_formatter_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Flow: decimal items pass through the shift-add-3 converter, hex items skip
//   it; then a scan drops leading zeros and sets the pad.
// Throughput: one item at a time, the next is taken only once the last char
//   of the current one is in the out register; chars leave one per cycle
//   (up to 62) while the output does not stall.
// Reset: rst_ni (async, active low) idles the sequencer, empties the out register.
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_unit
// printf-style formatting of one integer into a stream of ASCII characters:
// signed/unsigned decimal, lower/upper hex and pointer, with sign, 0x prefix,
// width/precision padding. A single BCD shift-add-3 unit does the decimal
// conversion one value bit per cycle.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_unit #(
  parameter int unsigned VALUE_BITS = 64,
  parameter int unsigned MAX_WIDTH  = 60
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire itoa_pkg::in_item_t  in_item_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output itoa_pkg::out_item_t      out_item_o
);

  // decimal digits needed for VALUE_BITS bits (log10(2) ~ 0.30103)
  localparam int unsigned NDIG_DEC = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int unsigned NDIG_HEX = (VALUE_BITS + 3) / 4;
  localparam int unsigned NDIG     = (NDIG_DEC > NDIG_HEX) ? NDIG_DEC : NDIG_HEX;
  localparam int unsigned DIG_BITS = 4 * NDIG;
  localparam int unsigned ND_W     = $clog2(NDIG + 1);
  localparam int unsigned CNT_W    = $clog2(VALUE_BITS + 1);
  localparam int unsigned WW       = itoa_pkg::WIDTH_W;
  localparam int unsigned CW       = itoa_pkg::CHAR_W;
  // compare width for field width vs digit count
  localparam int unsigned CMP_W    = ((WW > ND_W) ? WW : ND_W) + 1;

  itoa_pkg::state_e state_q, state_d;

  logic [VALUE_BITS-1:0] mag_q, mag_d;       // magnitude, shifted out MSB first
  logic [DIG_BITS-1:0]   dig_q, dig_d;       // BCD or hex nibbles, MSD at top
  logic [CNT_W-1:0]      cnt_q, cnt_d;       // conversion bits left
  logic [ND_W-1:0]       nd_q, nd_d;         // digits still to emit
  logic [WW-1:0]         width_q, width_d;   // effective field width
  logic [WW-1:0]         pad_q, pad_d;       // pad characters left
  logic                  zpad_q, zpad_d;
  logic                  upper_q, upper_d;
  logic [2*CW-1:0]       pre_q, pre_d;       // prefix chars, next one on top
  logic [1:0]            pre_n_q, pre_n_d;
  logic                  out_valid_q, out_valid_d;
  itoa_pkg::out_item_t   out_item_q, out_item_d;

  // ---- input decode --------------------------------------------------------
  logic [itoa_pkg::MODE_W-1:0] mode;
  logic [VALUE_BITS-1:0]       val;
  logic                        is_hex, neg, upper_in;
  logic [WW-1:0]               w0, w1;
  logic                        zp0;
  logic [DIG_BITS-1:0]         hex_dig;

  always_comb begin
    mode     = in_item_i.mode;
    val      = in_item_i.value[VALUE_BITS-1:0];
    is_hex   = (mode == itoa_pkg::MODE_HEXL) || (mode == itoa_pkg::MODE_HEXU) ||
               (mode == itoa_pkg::MODE_PTR);
    upper_in = (mode == itoa_pkg::MODE_HEXU);
    neg      = (mode == itoa_pkg::MODE_SDEC) && val[VALUE_BITS-1];
    // pointer defaults, then precision overrides, then saturate
    w0  = in_item_i.field_width;
    zp0 = in_item_i.zero_fill;
    if (mode == itoa_pkg::MODE_PTR) begin
      if (w0 == '0) begin
        w0 = itoa_pkg::PTR_DEF_WIDTH;
      end
      zp0 = 1'b1;
    end
    if (in_item_i.has_precision) begin
      w0  = in_item_i.precision;
      zp0 = 1'b1;
    end
    w1 = (w0 > WW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : w0;
    hex_dig = DIG_BITS'(val);
  end

  // ---- shared shift-add-3 step ---------------------------------------------
  logic [DIG_BITS-1:0] dd_adj;
  always_comb begin
    for (int k = 0; k < NDIG; k++) begin
      dd_adj[4*k +: 4] = (dig_q[4*k +: 4] >= 4'd5) ? dig_q[4*k +: 4] + 4'd3
                                                     : dig_q[4*k +: 4];
    end
  end

  // ---- shared terms --------------------------------------------------------
  logic              adv;        // output register can take a char
  logic              top_zero;
  logic              scan_more;
  logic [WW-1:0]     pad_calc;
  logic [3:0]        top_nib;

  assign adv       = !out_valid_q || !out_stall_i;
  assign top_nib   = dig_q[DIG_BITS-1 -: 4];
  assign top_zero  = (top_nib == 4'd0);
  assign scan_more = top_zero && (nd_q > ND_W'(1));

  always_comb begin
    if (CMP_W'(width_q) > CMP_W'(nd_q)) begin
      pad_calc = WW'(CMP_W'(width_q) - CMP_W'(nd_q));
    end else begin
      pad_calc = '0;
    end
  end

  // ---- next state ----------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      itoa_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = is_hex ? itoa_pkg::ST_SCAN : itoa_pkg::ST_CONV;
        end
      end
      itoa_pkg::ST_CONV: begin
        if (cnt_q == CNT_W'(1)) begin
          state_d = itoa_pkg::ST_SCAN;
        end
      end
      itoa_pkg::ST_SCAN: begin
        if (!scan_more) begin
          if (pre_n_q != 2'd0) begin
            state_d = itoa_pkg::ST_PREFIX;
          end else if (pad_calc != '0) begin
            state_d = itoa_pkg::ST_PAD;
          end else begin
            state_d = itoa_pkg::ST_DIGIT;
          end
        end
      end
      itoa_pkg::ST_PREFIX: begin
        if (adv && (pre_n_q == 2'd1)) begin
          state_d = (pad_q != '0) ? itoa_pkg::ST_PAD : itoa_pkg::ST_DIGIT;
        end
      end
      itoa_pkg::ST_PAD: begin
        if (adv && (pad_q == WW'(1))) begin
          state_d = itoa_pkg::ST_DIGIT;
        end
      end
      itoa_pkg::ST_DIGIT: begin
        if (adv && (nd_q == ND_W'(1))) begin
          state_d = itoa_pkg::ST_IDLE;
        end
      end
      default: state_d = itoa_pkg::ST_IDLE;
    endcase
  end

  // ---- datapath and outputs ------------------------------------------------
  always_comb begin
    mag_d       = mag_q;
    dig_d       = dig_q;
    cnt_d       = cnt_q;
    nd_d        = nd_q;
    width_d     = width_q;
    pad_d       = pad_q;
    zpad_d      = zpad_q;
    upper_d     = upper_q;
    pre_d       = pre_q;
    pre_n_d     = pre_n_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_item_d  = out_item_q;
    case (state_q)
      itoa_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          mag_d   = neg ? (~val + VALUE_BITS'(1)) : val;
          dig_d   = is_hex ? hex_dig : '0;
          cnt_d   = CNT_W'(VALUE_BITS);
          nd_d    = ND_W'(NDIG);
          width_d = w1;
          zpad_d  = zp0;
          upper_d = upper_in;
          pre_d   = '0;
          pre_n_d = 2'd0;
          if (is_hex) begin
            if (in_item_i.alt_form) begin
              pre_d   = {itoa_pkg::CH_ZERO, itoa_pkg::CH_X};
              pre_n_d = 2'd2;
            end
          end else if (neg) begin
            pre_d   = {itoa_pkg::CH_MINUS, CW'(0)};
            pre_n_d = 2'd1;
          end else if (in_item_i.force_plus) begin
            pre_d   = {itoa_pkg::CH_PLUS, CW'(0)};
            pre_n_d = 2'd1;
          end else if (in_item_i.space_sign) begin
            pre_d   = {itoa_pkg::CH_SPACE, CW'(0)};
            pre_n_d = 2'd1;
          end
        end
      end
      itoa_pkg::ST_CONV: begin
        dig_d = {dd_adj[DIG_BITS-2:0], mag_q[VALUE_BITS-1]};
        mag_d = {mag_q[VALUE_BITS-2:0], 1'b0};
        cnt_d = cnt_q - CNT_W'(1);
      end
      itoa_pkg::ST_SCAN: begin
        if (scan_more) begin
          dig_d = {dig_q[DIG_BITS-5:0], 4'd0};
          nd_d  = nd_q - ND_W'(1);
        end else begin
          pad_d = pad_calc;
        end
      end
      itoa_pkg::ST_PREFIX: begin
        if (adv) begin
          out_valid_d         = 1'b1;
          out_item_d.out_char = pre_q[2*CW-1 -: CW];
          out_item_d.last     = 1'b0;
          pre_d               = {pre_q[CW-1:0], CW'(0)};
          pre_n_d             = pre_n_q - 2'd1;
        end
      end
      itoa_pkg::ST_PAD: begin
        if (adv) begin
          out_valid_d         = 1'b1;
          out_item_d.out_char = zpad_q ? itoa_pkg::CH_ZERO : itoa_pkg::CH_SPACE;
          out_item_d.last     = 1'b0;
          pad_d               = pad_q - WW'(1);
        end
      end
      itoa_pkg::ST_DIGIT: begin
        if (adv) begin
          out_valid_d         = 1'b1;
          out_item_d.out_char = itoa_pkg::digit_char(top_nib, upper_q);
          out_item_d.last     = (nd_q == ND_W'(1));
          dig_d               = {dig_q[DIG_BITS-5:0], 4'd0};
          nd_d                = nd_q - ND_W'(1);
        end
      end
      default: begin
        out_valid_d = 1'b0;
      end
    endcase
  end

  // ---- registers -----------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= itoa_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q      <= mag_d;
    dig_q      <= dig_d;
    cnt_q      <= cnt_d;
    nd_q       <= nd_d;
    width_q    <= width_d;
    pad_q      <= pad_d;
    zpad_q     <= zpad_d;
    upper_q    <= upper_d;
    pre_q      <= pre_d;
    pre_n_q    <= pre_n_d;
    out_item_q <= out_item_d;
  end

  assign in_stall_o  = (state_q != itoa_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule
`default_nettype wire

@@ dv/integer_to_ascii_formatter_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_unit_tb
// Self-checking bench for the printf-style integer formatter. A short
// directed table covers the extremes, every conversion and the corner
// cases. About 300 random items follow. Every character that comes out is
// compared with a golden string or a local formatting function. Both
// handshakes see random gaps and stalls, with some bursts that have none.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_unit_tb;
  import itoa_pkg::*;

  // Spare conversion codes. The block formats them as unsigned decimal.
  localparam logic [MODE_W-1:0] MODE_SPARE5 = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE7 = 3'd7;

  localparam int unsigned FMT_VALUE_BITS = 64;
  localparam int unsigned FMT_MAX_WIDTH  = 60;
  localparam int unsigned RANDOM_ITEMS   = 300;
  // Quiet time at the end: a full decimal conversion, the leading-zero scan
  // and a maximum-length line, with margin.
  localparam int unsigned TAIL_CYCLES    = 256;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_item_o;

  // Characters still owed by the block, oldest first.
  out_item_t pending_chars[$];
  int unsigned mismatches;
  // Set during bursts. Both sides then run without gaps or stalls.
  logic no_idle;

  typedef struct {
    in_item_t item;
    string    golden;   // empty: the formatting function supplies the chars
  } dir_row_t;

  dir_row_t dir_rows[$];

  integer_to_ascii_formatter_unit #(
    .VALUE_BITS(FMT_VALUE_BITS),
    .MAX_WIDTH (FMT_MAX_WIDTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run-away guard. It lies several times past the slowest correct run
  // (every item at 62 chars with full stalls).
  initial begin
    #10_000_000;
    $display("integer_to_ascii_formatter_unit_tb: FAIL");
    $finish;
  end

  function automatic in_item_t fmt_item(input logic [MODE_W-1:0] mode,
                                        input logic [VALUE_W-1:0] value,
                                        input logic [WIDTH_W-1:0] fw,
                                        input logic zp, input logic plus,
                                        input logic spc, input logic alt,
                                        input logic hasp,
                                        input logic [WIDTH_W-1:0] prec);
    in_item_t it;
    it.mode          = mode;
    it.value         = value;
    it.field_width   = fw;
    it.zero_fill     = zp;
    it.force_plus    = plus;
    it.space_sign    = spc;
    it.alt_form      = alt;
    it.has_precision = hasp;
    it.precision     = prec;
    return it;
  endfunction

  function automatic void add_row(input in_item_t it, input string golden);
    dir_row_t r;
    r.item   = it;
    r.golden = golden;
    dir_rows.push_back(r);
  endfunction

  // Queue one line of characters and mark the final one.
  function automatic void owe_line(input logic [CHAR_W-1:0] line[$]);
    out_item_t c;
    foreach (line[k]) begin
      c.out_char = line[k];
      c.last     = (k == line.size() - 1);
      pending_chars.push_back(c);
    end
  endfunction

  // Formats one item the way the block should and queues the characters.
  function automatic void format_int(input in_item_t it);
    string             hex_lo = "0123456789abcdef";
    string             hex_up = "0123456789ABCDEF";
    logic [VALUE_W-1:0] mag;
    logic [CHAR_W-1:0]  digs[$];    // least significant digit first
    logic [CHAR_W-1:0]  line[$];
    int unsigned        wid;
    logic               zp;
    logic               hexy;
    mag  = it.value;
    wid  = 32'(it.field_width);
    zp   = it.zero_fill;
    hexy = (it.mode == MODE_HEXL) || (it.mode == MODE_HEXU) || (it.mode == MODE_PTR);
    // The pointer form defaults to 8 zero-padded digits. A precision still
    // overrides the width after that.
    if (it.mode == MODE_PTR) begin
      if (wid == 0) wid = 32'(PTR_DEF_WIDTH);
      zp = 1'b1;
    end
    if (it.has_precision) begin
      wid = 32'(it.precision);
      zp  = 1'b1;
    end
    if (wid > FMT_MAX_WIDTH) wid = FMT_MAX_WIDTH;

    if (hexy) begin
      // The prefix stays lower case even for the upper-case conversion.
      if (it.alt_form) begin
        line.push_back(CH_ZERO);
        line.push_back(CH_X);
      end
      do begin
        digs.push_back((it.mode == MODE_HEXU) ? hex_up[mag[3:0]] : hex_lo[mag[3:0]]);
        mag = mag >> 4;
      end while (mag != 0);
    end else begin
      // The most negative value wraps to itself. As unsigned it is the
      // exact magnitude.
      if (it.mode == MODE_SDEC && mag[VALUE_W-1]) begin
        line.push_back(CH_MINUS);
        mag = -mag;
      end else if (it.force_plus) begin
        line.push_back(CH_PLUS);
      end else if (it.space_sign) begin
        line.push_back(CH_SPACE);
      end
      do begin
        digs.push_back(CH_ZERO + CHAR_W'(mag % 10));
        mag = mag / 10;
      end while (mag != 0);
    end

    for (int unsigned k = digs.size(); k < wid; k++) line.push_back(zp ? CH_ZERO : CH_SPACE);
    while (digs.size() != 0) line.push_back(digs.pop_back());
    owe_line(line);
  endfunction

  // Present one item after a random gap and book its characters once it
  // is taken. Enter and leave at a falling edge.
  task automatic feed(input in_item_t it, input string golden);
    int unsigned       gap;
    logic [CHAR_W-1:0] line[$];
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (golden.len() == 0) begin
      format_int(it);
    end else begin
      for (int k = 0; k < golden.len(); k++) line.push_back(golden[k]);
      owe_line(line);
    end
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    while (pending_chars.size() != 0) @(negedge clk_i);
  endtask

  function automatic in_item_t random_item();
    logic [MODE_W-1:0]  modes[8] = '{MODE_SDEC, MODE_UDEC, MODE_HEXL, MODE_HEXU,
                                     MODE_PTR, MODE_SPARE5, MODE_SPARE6, MODE_SPARE7};
    logic [VALUE_W-1:0] v;
    logic [MODE_W-1:0]  m;
    logic [WIDTH_W-1:0] fw;
    logic [WIDTH_W-1:0] prec;
    logic               hasp;
    // The defined conversions dominate. The spare codes turn up now and then.
    m = ($urandom_range(0, 15) == 0) ? modes[$urandom_range(5, 7)]
                                     : modes[$urandom_range(0, 4)];
    case ($urandom_range(0, 5))
      0: v = {$urandom, $urandom};
      1: v = VALUE_W'($urandom_range(0, 999));
      2: v = -VALUE_W'($urandom_range(1, 999));     // small negative, sign-extended
      3: v = {$urandom, $urandom} >> $urandom_range(0, 63);
      4: v = VALUE_W'($urandom);
      default: begin
        case ($urandom_range(0, 3))
          0: v = '0;
          1: v = '1;
          2: v = {1'b1, {(VALUE_W-1){1'b0}}};
          default: v = {1'b0, {(VALUE_W-1){1'b1}}};
        endcase
      end
    endcase
    // Widths are mostly short. The long ones reach past the saturation limit.
    fw   = ($urandom_range(0, 7) == 0) ? WIDTH_W'($urandom_range(0, 63))
                                       : WIDTH_W'($urandom_range(0, 12));
    prec = ($urandom_range(0, 7) == 0) ? WIDTH_W'($urandom_range(0, 63))
                                       : WIDTH_W'($urandom_range(0, 12));
    hasp = ($urandom_range(0, 3) == 0);
    return fmt_item(m, v, fw, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), hasp, prec);
  endfunction

  // Result side: stall for a random count before each character, then
  // check it against the oldest one owed.
  initial begin : char_sink
    int unsigned hold;
    out_item_t   want;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      hold = no_idle ? 0 : $urandom_range(0, 7);
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      if (pending_chars.size() == 0) begin
        $error("unexpected character: out_char=%h last=%b",
               out_item_o.out_char, out_item_o.last);
        mismatches++;
      end else begin
        want = pending_chars.pop_front();
        if (out_item_o.out_char !== want.out_char) begin
          $error("out_char: expected %h, got %h", want.out_char, out_item_o.out_char);
          mismatches++;
        end
        if (out_item_o.last !== want.last) begin
          $error("last: expected %b, got %b", want.last, out_item_o.last);
          mismatches++;
        end
      end
      @(negedge clk_i);
    end
  end

  initial begin : stimulus
    logic [VALUE_W-1:0] most_neg;
    logic [VALUE_W-1:0] all_ones;
    most_neg    = {1'b1, {(VALUE_W-1){1'b0}}};
    all_ones    = '1;
    mismatches  = 0;
    no_idle     = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;

    //      mode       value        fw     zp    +     sp    alt   hasp  prec
    add_row(fmt_item(MODE_SDEC, 64'd0, 6'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 6'd0),
            "0");
    add_row(fmt_item(MODE_SDEC, most_neg, 6'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 6'd0),
            "-9223372036854775808");
    add_row(fmt_item(MODE_SDEC, ~most_neg, 6'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 6'd0),
            "9223372036854775807");
    add_row(fmt_item(MODE_UDEC, all_ones, 6'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 6'd0),
            "18446744073709551615");
    add_row(fmt_item(MODE_SDEC, all_ones, 6'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 6'd0),
            "-1");
    add_row(fmt_item(MODE_HEXL, all_ones, 6'd0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 6'd0),
            "0xffffffffffffffff");
    // upper-case digits, lower-case prefix
    add_row(fmt_item(MODE_HEXU, 64'hABCDEF, 6'd0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 6'd0),
            "0xABCDEF");
    // pointer defaults, then a precision overriding them
    add_row(fmt_item(MODE_PTR, 64'h1234, 6'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 6'd0),
            "00001234");
    add_row(fmt_item(MODE_PTR, 64'h1234, 6'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 6'd2),
            "1234");
    add_row(fmt_item(MODE_PTR, 64'd0, 6'd0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 6'd0),
            "0x00000000");
    // sign flags: plus beats space, and both apply to unsigned too
    add_row(fmt_item(MODE_SDEC, 64'd42, 6'd0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 6'd0),
            "+42");
    add_row(fmt_item(MODE_SDEC, 64'd42, 6'd0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 6'd0),
            " 42");
    add_row(fmt_item(MODE_SDEC, 64'd42, 6'd0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 6'd0),
            "+42");
    add_row(fmt_item(MODE_UDEC, 64'd7, 6'd0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 6'd0),
            " 7");
    // sign flags ignored in hex, alt flag ignored in decimal
    add_row(fmt_item(MODE_HEXL, 64'hFF, 6'd0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 6'd0),
            "ff");
    add_row(fmt_item(MODE_SDEC, 64'd5, 6'd0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 6'd0),
            "5");
    // padding goes after the sign
    add_row(fmt_item(MODE_SDEC, 64'd3, 6'd5, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 6'd0),
            "    3");
    add_row(fmt_item(MODE_SDEC, -64'd3, 6'd5, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 6'd0),
            "-00003");
    add_row(fmt_item(MODE_UDEC, 64'd99, 6'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 6'd5),
            "00099");
    // zero precision still gives one digit
    add_row(fmt_item(MODE_HEXL, 64'd0, 6'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 6'd0),
            "0");
    // spare codes act as unsigned decimal
    add_row(fmt_item(MODE_SPARE5, 64'd123, 6'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 6'd0), "");
    add_row(fmt_item(MODE_SPARE6, all_ones, 6'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 6'd0), "");
    add_row(fmt_item(MODE_SPARE7, 64'd0, 6'd3, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 6'd0), "");
    // widths past the limit saturate; the last row is the longest line
    add_row(fmt_item(MODE_UDEC, 64'd5, 6'd63, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 6'd0), "");
    add_row(fmt_item(MODE_HEXL, 64'hFF, 6'd0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 6'd63), "");

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[k]) feed(dir_rows[k].item, dir_rows[k].golden);
    // Hold back until the directed lines are all out.
    in_valid_i <= 1'b0;
    wait_drained();

    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      // a gap-free burst closes each stretch of 60 items
      no_idle = ((n % 60) >= 45);
      if (n % 100 == 50) begin
        in_valid_i <= 1'b0;
        wait_drained();
      end
      feed(random_item(), "");
    end
    in_valid_i <= 1'b0;
    no_idle    = 1'b0;

    wait_drained();
    // Stray characters would show up here.
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("integer_to_ascii_formatter_unit_tb: PASS");
    end else begin
      $display("integer_to_ascii_formatter_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
